// File: rtl/core/uafb_pkg.sv
// shared types and constants for the usb audio out feedback rate control core
// no dependencies

package uafb_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int RATE_W     = 32;
    localparam int STEP_W     = 16;
    localparam int PPC_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0] NOMINAL_RATE_RST = 32'd786432;
    localparam logic [STEP_W-1:0] RATE_STEP_RST    = 16'd64;
    localparam logic [PPC_W-1:0]  PPC_RST          = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PKTS_PER_CHK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_CHANNELS = 2'd3;

    typedef enum logic [1:0] {
        ACT_PKT_START = 2'd0,
        ACT_SAMPLE    = 2'd1,
        ACT_PKT_END   = 2'd2,
        ACT_STOP      = 2'd3
    } action_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic check;
        logic fill_half;
    } wr_status_t;

endpackage

// File: rtl/core/uafb_in_stage.sv
// input register stage: captures one beat and clamps the dma position
// depends on uafb_pkg

module uafb_in_stage
    import uafb_pkg::*;
#(
    parameter int HALF_WORDS = 1024,
    localparam int REM_W     = $clog2(HALF_WORDS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  action_t             s_action,
    input  logic [SAMPLE_W-1:0] s_left,
    input  logic [SAMPLE_W-1:0] s_right,
    input  logic                s_mute,
    input  logic [REM_W-1:0]    s_rem,
    input  logic                s_dma_half,
    input  logic                fire,
    output logic                in_valid,
    output action_t             action,
    output logic [SAMPLE_W-1:0] left,
    output logic [SAMPLE_W-1:0] right,
    output logic                mute,
    output logic [REM_W-1:0]    rem,
    output logic                dma_half
);

    localparam logic [REM_W-1:0] HALF_R = REM_W'(HALF_WORDS);

    logic                valid_reg;
    logic                valid_next;
    logic                take;
    logic [REM_W-1:0]    rem_clamp;
    action_t             action_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] right_reg;
    logic                mute_reg;
    logic [REM_W-1:0]    rem_reg;
    logic                dma_half_reg;

    assign s_ready   = !valid_reg || fire;
    assign take      = s_valid && s_ready;
    assign rem_clamp = (s_rem > HALF_R) ? HALF_R : s_rem;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg   <= s_action;
            left_reg     <= s_left;
            right_reg    <= s_right;
            mute_reg     <= s_mute;
            rem_reg      <= rem_clamp;
            dma_half_reg <= s_dma_half;
        end
    end

    assign in_valid = valid_reg;
    assign action   = action_reg;
    assign left     = left_reg;
    assign right    = right_reg;
    assign mute     = mute_reg;
    assign rem      = rem_reg;
    assign dma_half = dma_half_reg;

endmodule

// File: rtl/core/uafb_writer.sv
// playback buffer writer: stream state, write position, check countdown
// depends on uafb_pkg

module uafb_writer
    import uafb_pkg::*;
#(
    parameter int HALF_WORDS = 1024,
    localparam int REM_W     = $clog2(HALF_WORDS + 1),
    localparam int IDX_W     = $clog2(HALF_WORDS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_wr_t             cfg,
    input  logic                step,
    input  action_t             action,
    input  logic [SAMPLE_W-1:0] left,
    input  logic [SAMPLE_W-1:0] right,
    input  logic                mute,
    input  logic [REM_W-1:0]    rem,
    input  logic                dma_half,
    output logic                write_valid,
    output logic                write_half,
    output logic [IDX_W-1:0]    write_slot,
    output logic [SAMPLE_W-1:0] even_word,
    output logic [SAMPLE_W-1:0] odd_word,
    output wr_status_t          status,
    output logic [IDX_W-1:0]    write_index
);

    localparam logic [REM_W-1:0] HALF_R = REM_W'(HALF_WORDS);
    localparam logic [IDX_W:0]   HALF_I = (IDX_W + 1)'(HALF_WORDS);

    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic                fill_half_reg;
    logic                fill_half_next;
    logic                running_reg;
    logic                running_next;
    logic [PPC_W-1:0]    countdown_reg;
    logic [PPC_W-1:0]    countdown_next;
    logic [PPC_W-1:0]    ppc_reg;
    logic                swap_reg;
    logic [REM_W-1:0]    start_diff;
    logic [REM_W-1:0]    start_even;
    logic [IDX_W-1:0]    start_index;
    logic [IDX_W:0]      index_inc;
    logic [SAMPLE_W-1:0] l_word;
    logic [SAMPLE_W-1:0] r_word;

    assign start_diff  = HALF_R - rem;
    assign start_even  = {start_diff[REM_W-1:1], 1'b0};
    assign start_index = (start_even >= HALF_R) ? '0 : IDX_W'(start_even);
    assign index_inc   = {1'b0, index_reg} + (IDX_W + 1)'(2);
    assign l_word      = mute ? '0 : left;
    assign r_word      = mute ? '0 : right;

    always_comb
    begin
        index_next       = index_reg;
        fill_half_next   = fill_half_reg;
        running_next     = running_reg;
        countdown_next   = countdown_reg;
        write_valid      = 1'b0;
        write_half       = 1'b0;
        write_slot       = '0;
        even_word        = '0;
        odd_word         = '0;
        status.check     = 1'b0;
        status.fill_half = fill_half_reg;
        case (action)
            ACT_PKT_START:
            begin
                if (!running_reg)
                begin
                    running_next   = 1'b1;
                    countdown_next = '0;
                    fill_half_next = dma_half;
                    index_next     = start_index;
                end
            end
            ACT_SAMPLE:
            begin
                if (running_reg)
                begin
                    write_valid = 1'b1;
                    write_half  = fill_half_reg;
                    write_slot  = index_reg;
                    even_word   = swap_reg ? r_word : l_word;
                    odd_word    = swap_reg ? l_word : r_word;
                    if (index_inc >= HALF_I)
                    begin
                        index_next     = '0;
                        fill_half_next = !fill_half_reg;
                    end
                    else
                    begin
                        index_next = index_inc[IDX_W-1:0];
                    end
                end
            end
            ACT_PKT_END:
            begin
                if (running_reg)
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - PPC_W'(1);
                    end
                    else
                    begin
                        countdown_next = ppc_reg;
                        status.check   = 1'b1;
                    end
                end
            end
            ACT_STOP:
            begin
                running_next = 1'b0;
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    assign write_index = index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            fill_half_reg <= 1'b0;
            running_reg   <= 1'b0;
            countdown_reg <= '0;
            ppc_reg       <= PPC_RST;
            swap_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.en && cfg.idx == REG_PKTS_PER_CHK)
            begin
                ppc_reg <= cfg.data[PPC_W-1:0];
            end
            if (cfg.en && cfg.idx == REG_SWAP_CHANNELS)
            begin
                swap_reg <= cfg.data[0];
            end
            if (step)
            begin
                index_reg     <= index_next;
                fill_half_reg <= fill_half_next;
                running_reg   <= running_next;
                countdown_reg <= countdown_next;
            end
        end
    end

endmodule

// File: rtl/core/uafb_fb_ctrl.sv
// gap measurement and feedback rate adjustment with saturation
// depends on uafb_pkg

module uafb_fb_ctrl
    import uafb_pkg::*;
#(
    parameter int HALF_WORDS = 1024,
    localparam int REM_W     = $clog2(HALF_WORDS + 1),
    localparam int IDX_W     = $clog2(HALF_WORDS),
    localparam int GAP_W     = $clog2(3 * HALF_WORDS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_wr_t           cfg,
    input  logic              step,
    input  wr_status_t        status,
    input  logic [IDX_W-1:0]  write_index,
    input  logic [REM_W-1:0]  rem,
    input  logic              dma_half,
    output logic [RATE_W-1:0] feedback_rate,
    output logic [GAP_W-1:0]  measured_gap,
    output logic              slowing,
    output logic              speeding
);

    localparam logic [GAP_W-1:0] N1     = GAP_W'(HALF_WORDS);
    localparam logic [GAP_W-1:0] N2     = GAP_W'(2 * HALF_WORDS);
    localparam logic [GAP_W-1:0] N3     = GAP_W'(3 * HALF_WORDS);
    localparam logic [GAP_W-1:0] TH_LO2 = GAP_W'(HALF_WORDS * 2 / 4);
    localparam logic [GAP_W-1:0] TH_LO1 = GAP_W'(HALF_WORDS * 3 / 4);
    localparam logic [GAP_W-1:0] TH_HI1 = GAP_W'(HALF_WORDS * 5 / 4);
    localparam logic [GAP_W-1:0] TH_HI2 = GAP_W'(HALF_WORDS * 6 / 4);

    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] rate_next;
    logic [STEP_W-1:0] step_reg;
    logic [GAP_W-1:0]  prev_gap_reg;
    logic [GAP_W-1:0]  prev_gap_next;
    logic [GAP_W-1:0]  last_gap_reg;
    logic [GAP_W-1:0]  last_gap_next;
    logic [1:0]        flags_reg;
    logic [1:0]        flags_next;
    logic [GAP_W-1:0]  r_g;
    logic [GAP_W-1:0]  i_g;
    logic [GAP_W-1:0]  near_room;
    logic [GAP_W-1:0]  gap;
    logic              lower;
    logic              raise;
    logic              dbl;
    logic [STEP_W:0]   delta;
    logic [RATE_W:0]   rate_sum;

    assign r_g       = GAP_W'(rem);
    assign i_g       = GAP_W'(write_index);
    assign near_room = N1 - r_g;

    always_comb
    begin
        if (status.fill_half != dma_half)
        begin
            if (i_g < near_room)
            begin
                gap = near_room - i_g;
            end
            else
            begin
                gap = N3 - i_g - r_g;
            end
        end
        else
        begin
            gap = N2 - i_g - r_g;
        end
    end

    assign lower    = (gap < prev_gap_reg) && (gap < TH_LO1);
    assign raise    = (gap > prev_gap_reg) && (gap > TH_HI1);
    assign dbl      = lower ? (gap < TH_LO2) : (gap > TH_HI2);
    assign delta    = dbl ? {step_reg, 1'b0} : {1'b0, step_reg};
    assign rate_sum = {1'b0, rate_reg} + (RATE_W + 1)'(delta);

    always_comb
    begin
        rate_next     = rate_reg;
        prev_gap_next = prev_gap_reg;
        last_gap_next = last_gap_reg;
        flags_next    = flags_reg;
        if (status.check)
        begin
            last_gap_next = gap;
            if (lower)
            begin
                rate_next     = (rate_reg < RATE_W'(delta)) ? '0 : rate_reg - RATE_W'(delta);
                flags_next    = flags_reg | 2'b01;
                prev_gap_next = gap;
            end
            else if (raise)
            begin
                rate_next     = rate_sum[RATE_W] ? '1 : rate_sum[RATE_W-1:0];
                flags_next    = flags_reg | 2'b10;
                prev_gap_next = gap;
            end
            else
            begin
                flags_next = 2'b00;
            end
        end
    end

    assign feedback_rate = rate_next;
    assign measured_gap  = last_gap_next;
    assign slowing       = flags_next[0];
    assign speeding      = flags_next[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= NOMINAL_RATE_RST;
            step_reg     <= RATE_STEP_RST;
            prev_gap_reg <= N1;
            last_gap_reg <= '0;
            flags_reg    <= 2'b00;
        end
        else
        begin
            if (cfg.en && cfg.idx == REG_RATE_STEP)
            begin
                step_reg <= cfg.data[STEP_W-1:0];
            end
            if (cfg.en && cfg.idx == REG_NOMINAL_RATE)
            begin
                rate_reg <= cfg.data[RATE_W-1:0];
            end
            else if (step)
            begin
                rate_reg <= rate_next;
            end
            if (step)
            begin
                prev_gap_reg <= prev_gap_next;
                last_gap_reg <= last_gap_next;
                flags_reg    <= flags_next;
            end
        end
    end

endmodule

// File: rtl/core/uafb_out_stage.sv
// result register: holds one finished beat until the sink takes it
// depends on uafb_pkg

module uafb_out_stage
    import uafb_pkg::*;
#(
    parameter int HALF_WORDS = 1024,
    localparam int IDX_W     = $clog2(HALF_WORDS),
    localparam int GAP_W     = $clog2(3 * HALF_WORDS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                m_ready,
    output logic                free,
    output logic                m_valid,
    input  logic                d_write_valid,
    input  logic                d_write_half,
    input  logic [IDX_W-1:0]    d_write_slot,
    input  logic [SAMPLE_W-1:0] d_even_word,
    input  logic [SAMPLE_W-1:0] d_odd_word,
    input  logic [RATE_W-1:0]   d_feedback_rate,
    input  logic                d_gap_checked,
    input  logic [GAP_W-1:0]    d_measured_gap,
    input  logic                d_slowing,
    input  logic                d_speeding,
    output logic                write_valid,
    output logic                write_half,
    output logic [IDX_W-1:0]    write_slot,
    output logic [SAMPLE_W-1:0] even_word,
    output logic [SAMPLE_W-1:0] odd_word,
    output logic [RATE_W-1:0]   feedback_rate,
    output logic                gap_checked,
    output logic [GAP_W-1:0]    measured_gap,
    output logic                slowing,
    output logic                speeding
);

    logic                valid_reg;
    logic                valid_next;
    logic                write_valid_reg;
    logic                write_half_reg;
    logic [IDX_W-1:0]    write_slot_reg;
    logic [SAMPLE_W-1:0] even_word_reg;
    logic [SAMPLE_W-1:0] odd_word_reg;
    logic [RATE_W-1:0]   feedback_rate_reg;
    logic                gap_checked_reg;
    logic [GAP_W-1:0]    measured_gap_reg;
    logic                slowing_reg;
    logic                speeding_reg;

    assign free = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            write_valid_reg   <= d_write_valid;
            write_half_reg    <= d_write_half;
            write_slot_reg    <= d_write_slot;
            even_word_reg     <= d_even_word;
            odd_word_reg      <= d_odd_word;
            feedback_rate_reg <= d_feedback_rate;
            gap_checked_reg   <= d_gap_checked;
            measured_gap_reg  <= d_measured_gap;
            slowing_reg       <= d_slowing;
            speeding_reg      <= d_speeding;
        end
    end

    assign m_valid       = valid_reg;
    assign write_valid   = write_valid_reg;
    assign write_half    = write_half_reg;
    assign write_slot    = write_slot_reg;
    assign even_word     = even_word_reg;
    assign odd_word      = odd_word_reg;
    assign feedback_rate = feedback_rate_reg;
    assign gap_checked   = gap_checked_reg;
    assign measured_gap  = measured_gap_reg;
    assign slowing       = slowing_reg;
    assign speeding      = speeding_reg;

endmodule

// File: rtl/core/usb_audio_out_feedback_rate_control_core.sv
// top level of the usb audio out playback writer with feedback rate control
// depends on uafb_pkg, uafb_in_stage, uafb_writer, uafb_fb_ctrl, uafb_out_stage
//
// the slave stream carries usb audio out events: tuser holds the action
// (packet start, stereo pair, packet end, stream stopped) and tdata the two
// samples, mute and the playback dma position. every beat gives exactly one
// result beat on the master stream: an optional write of the pair into the
// ping-pong buffer plus the current feedback rate, gap and indicator flags.
// a beat is registered on entry, processed combinationally against the stream
// state and written to the result register, from which its result is offered.
// one beat is accepted every cycle while the sink keeps up; the processing
// register and the result register are both held while the sink stalls, and
// s_tready drops only when both are full, so it is high once reset is released.
// registers are written through cfg_wr_en, cfg_wr_index and cfg_wr_data; the
// user must write them only while the core is idle, which the core does not
// enforce. writing the nominal rate also loads the running rate. reset empties
// both registers, stops the stream and restores the register defaults.

module usb_audio_out_feedback_rate_control_core
    import uafb_pkg::*;
#(
    parameter int HALF_WORDS  = 1024,
    localparam int REM_W      = $clog2(HALF_WORDS + 1),
    localparam int IDX_W      = $clog2(HALF_WORDS),
    localparam int GAP_W      = $clog2(3 * HALF_WORDS + 1),
    localparam int IN_BITS    = 2 * SAMPLE_W + 2 + REM_W,
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = 1 + IDX_W + 2 * SAMPLE_W + RATE_W + GAP_W + 2,
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_sample, right_sample, mute, dma_remaining, dma_half, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // write_half, write_slot, even_word, odd_word, feedback_rate,
    // measured_gap, slowing_flag, speeding_flag, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // write_valid, gap_checked
    output logic [1:0]            m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int OFS_MUTE = 2 * SAMPLE_W;
    localparam int OFS_REM  = OFS_MUTE + 1;
    localparam int OFS_HALF = OFS_REM + REM_W;

    cfg_wr_t             cfg;
    wr_status_t          status;
    logic                fire;
    logic                in_valid;
    logic                out_free;
    action_t             action;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                mute;
    logic [REM_W-1:0]    rem;
    logic                dma_half;
    logic [IDX_W-1:0]    write_index;
    logic                d_write_valid;
    logic                d_write_half;
    logic [IDX_W-1:0]    d_write_slot;
    logic [SAMPLE_W-1:0] d_even_word;
    logic [SAMPLE_W-1:0] d_odd_word;
    logic [RATE_W-1:0]   d_feedback_rate;
    logic [GAP_W-1:0]    d_measured_gap;
    logic                d_slowing;
    logic                d_speeding;
    logic                q_write_valid;
    logic                q_write_half;
    logic [IDX_W-1:0]    q_write_slot;
    logic [SAMPLE_W-1:0] q_even_word;
    logic [SAMPLE_W-1:0] q_odd_word;
    logic [RATE_W-1:0]   q_feedback_rate;
    logic                q_gap_checked;
    logic [GAP_W-1:0]    q_measured_gap;
    logic                q_slowing;
    logic                q_speeding;

    assign cfg.en   = cfg_wr_en;
    assign cfg.idx  = cfg_wr_index;
    assign cfg.data = cfg_wr_data;
    assign fire     = in_valid && out_free;

    uafb_in_stage #(.HALF_WORDS(HALF_WORDS)) u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_action   (action_t'(s_tuser)),
        .s_left     (s_tdata[SAMPLE_W-1:0]),
        .s_right    (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .s_mute     (s_tdata[OFS_MUTE]),
        .s_rem      (s_tdata[OFS_REM +: REM_W]),
        .s_dma_half (s_tdata[OFS_HALF]),
        .fire       (fire),
        .in_valid   (in_valid),
        .action     (action),
        .left       (left),
        .right      (right),
        .mute       (mute),
        .rem        (rem),
        .dma_half   (dma_half)
    );

    uafb_writer #(.HALF_WORDS(HALF_WORDS)) u_writer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (fire),
        .action      (action),
        .left        (left),
        .right       (right),
        .mute        (mute),
        .rem         (rem),
        .dma_half    (dma_half),
        .write_valid (d_write_valid),
        .write_half  (d_write_half),
        .write_slot  (d_write_slot),
        .even_word   (d_even_word),
        .odd_word    (d_odd_word),
        .status      (status),
        .write_index (write_index)
    );

    uafb_fb_ctrl #(.HALF_WORDS(HALF_WORDS)) u_fb_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (fire),
        .status        (status),
        .write_index   (write_index),
        .rem           (rem),
        .dma_half      (dma_half),
        .feedback_rate (d_feedback_rate),
        .measured_gap  (d_measured_gap),
        .slowing       (d_slowing),
        .speeding      (d_speeding)
    );

    uafb_out_stage #(.HALF_WORDS(HALF_WORDS)) u_out_stage
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .m_ready         (m_tready),
        .free            (out_free),
        .m_valid         (m_tvalid),
        .d_write_valid   (d_write_valid),
        .d_write_half    (d_write_half),
        .d_write_slot    (d_write_slot),
        .d_even_word     (d_even_word),
        .d_odd_word      (d_odd_word),
        .d_feedback_rate (d_feedback_rate),
        .d_gap_checked   (status.check),
        .d_measured_gap  (d_measured_gap),
        .d_slowing       (d_slowing),
        .d_speeding      (d_speeding),
        .write_valid     (q_write_valid),
        .write_half      (q_write_half),
        .write_slot      (q_write_slot),
        .even_word       (q_even_word),
        .odd_word        (q_odd_word),
        .feedback_rate   (q_feedback_rate),
        .gap_checked     (q_gap_checked),
        .measured_gap    (q_measured_gap),
        .slowing         (q_slowing),
        .speeding        (q_speeding)
    );

    assign m_tdata = OUT_DATA_W'({q_speeding, q_slowing, q_measured_gap, q_feedback_rate,
                                  q_odd_word, q_even_word, q_write_slot, q_write_half});
    assign m_tuser = {q_gap_checked, q_write_valid};

    // a processed beat always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n) fire |=> m_tvalid)
        else $error("processed beat missing from result register");

    // a beat is never both a buffer write and a gap check
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(d_write_valid && status.check))
        else $error("write and gap check in the same beat");

    // the writer only ever addresses the even word of a pair inside the half
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && d_write_valid) |-> (!d_write_slot[0] && (32'(d_write_slot) < HALF_WORDS)))
        else $error("write slot odd or outside the half");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for usb_audio_out_feedback_rate_control_core: directed and
// random usb audio out events, every result beat compared with a behavioural predictor
// depends on uafb_pkg and the core rtl

module tb_top
    import uafb_pkg::*;
();

    localparam int HALF = 1024;
    localparam int IN_W = 64;
    localparam int OUT_W = 112;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam longint RATE_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic        write_valid;
        logic        write_half;
        logic [9:0]  write_slot;
        logic [23:0] even_word;
        logic [23:0] odd_word;
        logic [31:0] feedback_rate;
        logic        gap_checked;
        logic [11:0] measured_gap;
        logic        slowing_flag;
        logic        speeding_flag;
    } playback_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // predictor state and register shadows
    int          wr_index;
    logic        fill_half;
    logic        stream_on;
    int          chk_count;
    int          prev_gap;
    logic [31:0] fb_rate;
    int          last_gap;
    logic        slow_flag;
    logic        speed_flag;
    logic [15:0] cfg_step;
    logic [7:0]  cfg_ppc;
    logic        cfg_swap;

    playback_result_t expected_q[$];
    int err_count = 0;
    int live_items = 0;
    int sink_hold_cycles = 0;
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;

    usb_audio_out_feedback_rate_control_core #(
        .HALF_WORDS(HALF)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic playback_result_t play_event(action_t act, logic [23:0] left,
            logic [23:0] right, logic mute, logic [10:0] rem_raw, logic dhalf);
        playback_result_t res;
        int rem;
        int gap;
        longint nxt;
        res = '0;
        rem = (rem_raw > HALF) ? HALF : int'(rem_raw);
        nxt = longint'(fb_rate);
        case (act)
            ACT_PKT_START:
            begin
                if (!stream_on)
                begin
                    stream_on = 1'b1;
                    chk_count = 0;
                    fill_half = dhalf;
                    wr_index = (HALF - rem) & ~1;
                    if (wr_index >= HALF)
                        wr_index = 0;
                end
            end
            ACT_SAMPLE:
            begin
                if (stream_on)
                begin
                    res.write_valid = 1'b1;
                    res.write_half = fill_half;
                    res.write_slot = wr_index[9:0];
                    res.even_word = mute ? 24'h0 : (cfg_swap ? right : left);
                    res.odd_word = mute ? 24'h0 : (cfg_swap ? left : right);
                    wr_index += 2;
                    if (wr_index >= HALF)
                    begin
                        wr_index = 0;
                        fill_half = ~fill_half;
                    end
                end
            end
            ACT_PKT_END:
            begin
                if (stream_on && chk_count != 0)
                    chk_count--;
                else if (stream_on)
                begin
                    chk_count = cfg_ppc;
                    res.gap_checked = 1'b1;
                    if (fill_half != dhalf)
                        gap = (wr_index < HALF - rem) ? HALF - rem - wr_index
                                                      : 3 * HALF - wr_index - rem;
                    else
                        gap = 2 * HALF - wr_index - rem;
                    last_gap = gap;
                    // writer too close to the reader: slow down, too far: speed up
                    if (gap < prev_gap && gap < HALF * 2 / 4)
                    begin
                        nxt = longint'(fb_rate) - 2 * longint'(cfg_step);
                        slow_flag = 1'b1;
                        prev_gap = gap;
                    end
                    else if (gap < prev_gap && gap < HALF * 3 / 4)
                    begin
                        nxt = longint'(fb_rate) - longint'(cfg_step);
                        slow_flag = 1'b1;
                        prev_gap = gap;
                    end
                    else if (gap > prev_gap && gap > HALF * 6 / 4)
                    begin
                        nxt = longint'(fb_rate) + 2 * longint'(cfg_step);
                        speed_flag = 1'b1;
                        prev_gap = gap;
                    end
                    else if (gap > prev_gap && gap > HALF * 5 / 4)
                    begin
                        nxt = longint'(fb_rate) + longint'(cfg_step);
                        speed_flag = 1'b1;
                        prev_gap = gap;
                    end
                    else
                    begin
                        slow_flag = 1'b0;
                        speed_flag = 1'b0;
                    end
                end
            end
            default:
            begin
                stream_on = 1'b0;
            end
        endcase
        fb_rate = (nxt < 0) ? 32'h0 : (nxt > RATE_MAX) ? 32'hFFFF_FFFF : nxt[31:0];
        res.feedback_rate = fb_rate;
        res.measured_gap = last_gap[11:0];
        res.slowing_flag = slow_flag;
        res.speeding_flag = speed_flag;
        return res;
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] rand_remaining();
        case ($urandom_range(0, 19))
            0: return 11'd0;
            1: return 11'd1024;
            2: return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(0, 1024));
        endcase
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        $display("%0t ns: mismatch, %s", $time, what);
    endtask

    task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic send_event(action_t act, logic [23:0] left, logic [23:0] right,
            logic mute, logic [10:0] rem, logic dhalf);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {3'b000, dhalf, rem, mute, right, left};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (stream_on || act == ACT_PKT_START || act == ACT_STOP)
            live_items++;
        expected_q.push_back(play_event(act, left, right, mute, rem, dhalf));
    endtask

    task automatic send_packet(int pairs);
        send_event(ACT_PKT_START, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                   rand_remaining(), 1'($urandom_range(0, 1)));
        repeat (pairs)
            send_event(ACT_SAMPLE, rand_sample(), rand_sample(), $urandom_range(0, 7) == 0,
                       rand_remaining(), 1'($urandom_range(0, 1)));
        send_event(ACT_PKT_END, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                   rand_remaining(), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        case (idx)
            REG_NOMINAL_RATE:
            begin
                fb_rate = data;
            end
            REG_RATE_STEP: cfg_step = data[15:0];
            REG_PKTS_PER_CHK: cfg_ppc = data[7:0];
            REG_SWAP_CHANNELS: cfg_swap = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] nominal, logic [15:0] step, logic [7:0] ppc,
            logic swap);
        wait_results_done();
        write_reg(REG_NOMINAL_RATE, nominal);
        write_reg(REG_RATE_STEP, {16'h0, step});
        write_reg(REG_PKTS_PER_CHK, {24'h0, ppc});
        write_reg(REG_SWAP_CHANNELS, {31'h0, swap});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_stopped_stream();
        send_event(ACT_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 11'd1024, 1'b1);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd0, 1'b0);
        send_event(ACT_STOP, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 11'h7FF, 1'b1);
    endtask

    task automatic test_start_alignment();
        // nothing left in the dma half: index wraps to zero
        send_event(ACT_PKT_START, 24'h0, 24'h0, 1'b0, 11'd0, 1'b1);
        send_event(ACT_SAMPLE, 24'hFFFFFF, 24'h000000, 1'b0, 11'd512, 1'b0);
        send_event(ACT_SAMPLE, 24'h000000, 24'hFFFFFF, 1'b0, 11'd512, 1'b0);
        send_event(ACT_PKT_START, 24'h0, 24'h0, 1'b0, 11'd500, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'h7FF, 1'b0);
        send_event(ACT_STOP, 24'h0, 24'h0, 1'b0, 11'd0, 1'b0);
        // odd remaining count, then writes across the end of the half
        send_event(ACT_PKT_START, 24'h0, 24'h0, 1'b0, 11'd3, 1'b0);
        repeat (3)
            send_event(ACT_SAMPLE, rand_sample(), rand_sample(), 1'b0, 11'd0, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd1024, 1'b1);
    endtask

    task automatic test_swap_and_mute();
        set_config(NOMINAL_RATE_RST, RATE_STEP_RST, 8'd0, 1'b1);
        send_event(ACT_SAMPLE, 24'h123456, 24'hABCDEF, 1'b0, 11'd7, 1'b0);
        send_event(ACT_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 11'd7, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd1, 1'b1);
    endtask

    task automatic test_rate_saturation();
        set_config(32'hFFFF_0000, 16'hFFFF, 8'd0, 1'b0);
        send_event(ACT_STOP, 24'h0, 24'h0, 1'b0, 11'd0, 1'b0);
        send_event(ACT_PKT_START, 24'h0, 24'h0, 1'b0, 11'd1024, 1'b0);
        // rising gaps push the rate into the top limit
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd1000, 1'b1);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd1024, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd700, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd400, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd0, 1'b0);
        // falling gaps drive it down to zero
        set_config(32'h0001_0000, 16'hFFFF, 8'd0, 1'b0);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd300, 1'b1);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd600, 1'b1);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd1000, 1'b1);
        send_event(ACT_PKT_END, 24'h0, 24'h0, 1'b0, 11'd1000, 1'b1);
    endtask

    task automatic test_sink_backpressure();
        sink_hold_cycles = 80;
        send_packet(16);
        wait_results_done();
    endtask

    task automatic run_random_phase(logic [31:0] nominal, logic [15:0] step,
            logic [7:0] ppc, logic swap, int items, bit allow_idle);
        int target;
        int kind;
        set_config(nominal, step, ppc, swap);
        target = live_items + items;
        src_idle_en = allow_idle;
        sink_idle_en = allow_idle;
        while (live_items < target)
        begin
            if (allow_idle && $urandom_range(0, 39) == 0)
            begin
                src_idle_en = $urandom_range(0, 1);
                sink_idle_en = $urandom_range(0, 1);
            end
            kind = $urandom_range(0, 99);
            if (kind < 6)
                send_event(ACT_STOP, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                           rand_remaining(), 1'($urandom_range(0, 1)));
            else if (kind < 80)
                send_packet($urandom_range(0, 12));
            else
                send_event(action_t'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                           1'($urandom_range(0, 1)), rand_remaining(),
                           1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(NOMINAL_RATE_RST, RATE_STEP_RST, 8'd0, 1'b0, 130, 1'b1);
        run_random_phase(NOMINAL_RATE_RST, RATE_STEP_RST, 8'd1, 1'b1, 130, 1'b1);
        run_random_phase(32'h0, 16'hFFFF, 8'd2, 1'b0, 130, 1'b1);
        run_random_phase(32'hFFFF_FFFF, 16'h0, 8'd0, 1'b1, 130, 1'b1);
        run_random_phase($urandom, 16'($urandom_range(0, 65535)), 8'd255,
                         1'($urandom_range(0, 1)), 130, 1'b1);
        run_random_phase($urandom, 16'($urandom_range(0, 1023)), 8'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 130, 1'b0);
    endtask

    always @(posedge clk)
    begin : result_check
        playback_result_t got;
        playback_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.write_valid = m_tuser[0];
            got.gap_checked = m_tuser[1];
            got.write_half = m_tdata[0];
            got.write_slot = m_tdata[10:1];
            got.even_word = m_tdata[34:11];
            got.odd_word = m_tdata[58:35];
            got.feedback_rate = m_tdata[90:59];
            got.measured_gap = m_tdata[102:91];
            got.slowing_flag = m_tdata[103];
            got.speeding_flag = m_tdata[104];
            if (expected_q.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = expected_q.pop_front();
                cmp_field("write_valid", got.write_valid, want.write_valid);
                cmp_field("write_half", got.write_half, want.write_half);
                cmp_field("write_slot", got.write_slot, want.write_slot);
                cmp_field("even_word", got.even_word, want.even_word);
                cmp_field("odd_word", got.odd_word, want.odd_word);
                cmp_field("feedback_rate", got.feedback_rate, want.feedback_rate);
                cmp_field("gap_checked", got.gap_checked, want.gap_checked);
                cmp_field("measured_gap", got.measured_gap, want.measured_gap);
                cmp_field("slowing_flag", got.slowing_flag, want.slowing_flag);
                cmp_field("speeding_flag", got.speeding_flag, want.speeding_flag);
            end
        end
    end

    // sink side: random stalls plus an occasional long hold-off
    initial
    begin : sink_drive
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("usb_audio_out_feedback_rate_control_core test failed");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= ACT_PKT_START;
        m_tready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_index <= REG_NOMINAL_RATE;
        cfg_wr_data <= '0;
        cfg_step = RATE_STEP_RST;
        cfg_ppc = PPC_RST;
        cfg_swap = 1'b0;
        wr_index = 0;
        fill_half = 1'b0;
        stream_on = 1'b0;
        chk_count = 0;
        prev_gap = HALF;
        fb_rate = NOMINAL_RATE_RST;
        last_gap = 0;
        slow_flag = 1'b0;
        speed_flag = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stopped_stream();
        test_start_alignment();
        test_swap_and_mute();
        test_rate_saturation();
        test_sink_backpressure();
        test_random_traffic();
        wait_results_done();
        if (err_count == 0)
            $display("usb_audio_out_feedback_rate_control_core test passed");
        else
            $display("usb_audio_out_feedback_rate_control_core test failed");
        $finish;
    end

endmodule
